// ===== sv/dar_pkg.sv =====
// ---------------------------------------------------------------------------
// Daily alarm ringer package
// Shared word types, register indexes and constants for the alarm block.
// ---------------------------------------------------------------------------
package dar_pkg;

    // Time base.
    localparam int unsigned  TIME_W        = 48;
    localparam logic [31:0]  US_PER_SECOND = 32'd1000000;

    // Field widths.
    localparam int unsigned  HOUR_W        = 5;
    localparam int unsigned  MINUTE_W      = 6;
    localparam int unsigned  DAY_W         = 9;
    localparam int unsigned  MAX_RING_S_W  = 12;
    localparam int unsigned  INTERVAL_S_W  = 8;

    // Scaled thresholds in microseconds: 4095 s and 255 s fit these widths.
    localparam int unsigned  MAX_RING_US_W = 32;
    localparam int unsigned  INTERVAL_US_W = 28;

    // Saturation limits for the set time.
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;

    // Day latch value that means no day has fired yet.
    localparam logic [DAY_W-1:0]    NO_DAY     = 9'd511;

    // Register reset values.
    localparam logic [HOUR_W-1:0]        RST_ALARM_HOUR   = 5'd7;
    localparam logic [MINUTE_W-1:0]      RST_ALARM_MINUTE = 6'd0;
    localparam logic                     RST_ALARM_EN     = 1'b0;
    localparam logic [MAX_RING_US_W-1:0] RST_MAX_RING_US  = 32'd300000000;
    localparam logic [INTERVAL_US_W-1:0] RST_INTERVAL_US  = 28'd5000000;

    // Configuration port.
    localparam int unsigned  CFG_IDX_W  = 3;
    localparam int unsigned  CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RING_SEC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_INTERVAL   = 3'd4;

    // Input item kinds.
    localparam logic KIND_CHECK   = 1'b0;
    localparam logic KIND_DISMISS = 1'b1;

    // Input word.
    typedef struct packed {
        logic                kind;
        logic [TIME_W-1:0]   now_us;
        logic [HOUR_W-1:0]   local_hour;
        logic [MINUTE_W-1:0] local_minute;
        logic [DAY_W-1:0]    day_of_year;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic fired;
        logic ring_tick;
        logic dismissed;
        logic ringing;
    } t_out_word;

    // Active settings handed from the register file to the core.
    typedef struct packed {
        logic [HOUR_W-1:0]        alarm_hour;
        logic [MINUTE_W-1:0]      alarm_minute;
        logic                     alarm_enabled;
        logic [MAX_RING_US_W-1:0] max_ring_us;
        logic [INTERVAL_US_W-1:0] ring_interval_us;
    } t_cfg;

endpackage

// ===== sv/dar_cfg.sv =====
// ---------------------------------------------------------------------------
// Daily alarm register file
// Holds the alarm settings, saturates the set time and keeps both time
// limits pre-scaled to microseconds so the core only compares.
// ---------------------------------------------------------------------------
module dar_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [dar_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [dar_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output dar_pkg::t_cfg                   o_cfg
);

    dar_pkg::t_cfg r_cfg;
    dar_pkg::t_cfg n_cfg;

    logic [dar_pkg::HOUR_W-1:0]        wr_hour;
    logic [dar_pkg::MINUTE_W-1:0]      wr_minute;
    logic [dar_pkg::MAX_RING_US_W-1:0] wr_max_us;
    logic [dar_pkg::INTERVAL_US_W-1:0] wr_int_us;

    // Saturate the set time and scale seconds to microseconds.
    always_comb begin
        wr_hour   = i_wr_data[dar_pkg::HOUR_W-1:0];
        wr_minute = i_wr_data[dar_pkg::MINUTE_W-1:0];
        if (wr_hour > dar_pkg::HOUR_MAX) begin
            wr_hour = dar_pkg::HOUR_MAX;
        end
        if (wr_minute > dar_pkg::MINUTE_MAX) begin
            wr_minute = dar_pkg::MINUTE_MAX;
        end
        wr_max_us = dar_pkg::MAX_RING_US_W'(i_wr_data[dar_pkg::MAX_RING_S_W-1:0])
                  * dar_pkg::MAX_RING_US_W'(dar_pkg::US_PER_SECOND);
        wr_int_us = dar_pkg::INTERVAL_US_W'(i_wr_data[dar_pkg::INTERVAL_S_W-1:0])
                  * dar_pkg::INTERVAL_US_W'(dar_pkg::US_PER_SECOND);
    end

    // Register write decode; unknown indexes are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                dar_pkg::CFG_ALARM_HOUR:    n_cfg.alarm_hour       = wr_hour;
                dar_pkg::CFG_ALARM_MINUTE:  n_cfg.alarm_minute     = wr_minute;
                dar_pkg::CFG_ALARM_ENABLED: n_cfg.alarm_enabled    = i_wr_data[0];
                dar_pkg::CFG_MAX_RING_SEC:  n_cfg.max_ring_us      = wr_max_us;
                dar_pkg::CFG_RING_INTERVAL: n_cfg.ring_interval_us = wr_int_us;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_hour       <= dar_pkg::RST_ALARM_HOUR;
            r_cfg.alarm_minute     <= dar_pkg::RST_ALARM_MINUTE;
            r_cfg.alarm_enabled    <= dar_pkg::RST_ALARM_EN;
            r_cfg.max_ring_us      <= dar_pkg::RST_MAX_RING_US;
            r_cfg.ring_interval_us <= dar_pkg::RST_INTERVAL_US;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/dar_core.sv =====
// ---------------------------------------------------------------------------
// Daily alarm core
// Evaluates one registered word per cycle, while the output register is free
// or drained, against the ringing state and loads the result word into it.
// ---------------------------------------------------------------------------
module dar_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dar_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  dar_pkg::t_in_word  i_word,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dar_pkg::t_out_word o_out_data
);

    logic                          r_firing;
    logic [dar_pkg::TIME_W-1:0]    r_start_us;
    logic [dar_pkg::TIME_W-1:0]    r_last_us;
    logic [dar_pkg::DAY_W-1:0]     r_last_day;
    logic                          r_out_valid;
    dar_pkg::t_out_word            r_out;

    logic                          n_firing;
    logic [dar_pkg::TIME_W-1:0]    n_start_us;
    logic [dar_pkg::TIME_W-1:0]    n_last_us;
    logic [dar_pkg::DAY_W-1:0]     n_last_day;
    dar_pkg::t_out_word            n_out;

    logic                          advance;
    logic [dar_pkg::TIME_W-1:0]    since_start;
    logic [dar_pkg::TIME_W-1:0]    since_last;
    logic                          timed_out;
    logic                          tick_due;
    logic                          time_match;

    // The core moves whenever the output register is free or being drained.
    assign o_ready = !r_out_valid || i_out_ready;
    assign advance = i_valid && o_ready;

    // Elapsed times wrap modulo 2^48; limits are already in microseconds.
    assign since_start = i_word.now_us - r_start_us;
    assign since_last  = i_word.now_us - r_last_us;
    assign timed_out   = since_start >= dar_pkg::TIME_W'(i_cfg.max_ring_us);
    assign tick_due    = since_last  >= dar_pkg::TIME_W'(i_cfg.ring_interval_us);
    assign time_match  = i_cfg.alarm_enabled
                      && (i_word.local_hour   == i_cfg.alarm_hour)
                      && (i_word.local_minute == i_cfg.alarm_minute)
                      && (i_word.day_of_year  != r_last_day);

    // Next ringing state and result word.
    always_comb begin
        n_firing   = r_firing;
        n_start_us = r_start_us;
        n_last_us  = r_last_us;
        n_last_day = r_last_day;
        n_out      = '0;
        if (i_word.kind == dar_pkg::KIND_DISMISS) begin
            if (r_firing) begin
                n_firing        = 1'b0;
                n_out.dismissed = 1'b1;
            end
        end else if (r_firing) begin
            if (timed_out) begin
                n_firing        = 1'b0;
                n_out.dismissed = 1'b1;
            end else if (tick_due) begin
                n_last_us       = i_word.now_us;
                n_out.ring_tick = 1'b1;
            end
        end else if (time_match) begin
            n_firing    = 1'b1;
            n_start_us  = i_word.now_us;
            n_last_us   = i_word.now_us;
            n_last_day  = i_word.day_of_year;
            n_out.fired = 1'b1;
        end
        n_out.ringing = n_firing;
    end

    // Ringing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_firing   <= 1'b0;
            r_start_us <= '0;
            r_last_us  <= '0;
            r_last_day <= dar_pkg::NO_DAY;
        end else if (advance) begin
            r_firing   <= n_firing;
            r_start_us <= n_start_us;
            r_last_us  <= n_last_us;
            r_last_day <= n_last_day;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= advance;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result never both starts and stops the ringing or ticks on a start.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_out.fired, r_out.ring_tick, r_out.dismissed}) <= 1)
        else $error("more than one event flag in a result word");

    // The reported status agrees with the stored ringing state.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(advance)) |-> (r_out.ringing == r_firing))
        else $error("ringing status differs from the ringing state");

    // Firing latches the day of the triggering word.
    a_day_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_out.fired) |=> (r_firing && r_last_day == $past(i_word.day_of_year)))
        else $error("fire did not latch the ringing state and day");

    // A ring tick or a dismiss only happens while ringing.
    a_event_needs_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (n_out.ring_tick || n_out.dismissed)) |-> r_firing)
        else $error("tick or dismiss while not ringing");

endmodule

// ===== sv/daily_alarm_ringer.sv =====
// ---------------------------------------------------------------------------
// Daily alarm ringer
// Top level: input register, register file and evaluation core.
// ---------------------------------------------------------------------------
// Each accepted word gives exactly one result word. A word is taken into the
// input register, evaluated from there against the ringing state, and its
// result is loaded into the output register, and a new word can be accepted
// every cycle. The only thing that slows intake is a result register that
// the consumer leaves full. Time limits are scaled to microseconds when the
// registers are written, so configuration takes effect on the next word;
// write it only while no word is in flight.
module daily_alarm_ringer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dar_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dar_pkg::t_out_word              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dar_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dar_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic              r_in_valid;
    dar_pkg::t_in_word r_in;
    dar_pkg::t_cfg     cfg;
    logic              core_ready;

    // Registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    dar_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Input register: refilled whenever empty or drained into the core.
    assign o_in_ready = !r_in_valid || core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    dar_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (r_in_valid),
        .i_word      (r_in),
        .o_ready     (core_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
